// ===== sv/topk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the top-K replace-worst table.
// Used by topk_mem, topk_scan and topk_replace_worst; depends on nothing.
package topk_pkg;

    localparam int K_ENTRIES_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int RIDX_W        = 8;
    localparam int SLOT_W        = 8;
    localparam int HELD_W        = 9;
    localparam int CMD_W         = 2;
    localparam int ENTRY_W       = 2 * DATA_W;
    localparam int S_TDATA_W     = 72;
    localparam int M_TDATA_W     = 88;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DECIDE,
        ST_RDWAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic en;
        logic first;
        logic decide;
    } scan_ctrl_t;

endpackage

// ===== sv/topk_mem.sv =====
`timescale 1ns / 1ps
// Entry store: one write port, one read port with registered read data.
// Depends on topk_pkg for the entry width.
module topk_mem
    import topk_pkg::*;
#(
    parameter int DEPTH  = K_ENTRIES_DEF,
    parameter int ADDR_W = 4
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/topk_scan.sv =====
`timescale 1ns / 1ps
// Worst-entry tracker around one shared magnitude comparator.
// The comparator serves the scan and the final replace decision. Depends on topk_pkg.
module topk_scan
    import topk_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic              clk,
    input  scan_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] cand_dist,
    input  logic [IDX_W-1:0]  cand_idx,
    input  logic [DATA_W-1:0] new_dist,
    output logic [IDX_W-1:0]  worst_idx,
    output logic              gt
);

    logic [DATA_W-1:0] worst_dist_reg;
    logic [IDX_W-1:0]  worst_idx_reg;
    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] cmp_b;

    always_comb
    begin
        cmp_a = ctrl.decide ? worst_dist_reg : cand_dist;
        cmp_b = ctrl.decide ? new_dist : worst_dist_reg;
        gt    = cmp_a > cmp_b;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en && (ctrl.first || gt))
        begin
            worst_dist_reg <= cand_dist;
            worst_idx_reg  <= cand_idx;
        end
    end

    assign worst_idx = worst_idx_reg;

endmodule

// ===== sv/topk_replace_worst.sv =====
`timescale 1ns / 1ps
// Top-K smallest-distance table with replace-worst insertion; top level.
// Depends on topk_pkg, topk_mem and topk_scan.
//
// One item at a time; s_tready is high only while the sequencer is idle. An insert into
// a table that is not full, a clear, an unused command or a read of an index beyond the
// held entries goes from ST_EXEC to ST_FINISH; a read in range goes by ST_RDWAIT. An
// insert into a full table scans: every entry is read once through the single read port
// of the entry store and checked by one comparator, which then decides the replacement.
// Results are held in an output register; a stalled m_tready holds the next item in ST_FINISH.
module topk_replace_worst
    import topk_pkg::*;
#(
    parameter int K_ENTRIES = K_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] vec_id, [63:32] distance, [71:64] read_index
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]     s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] accepted, [8:1] slot, [17:9] held_count, [18] entry_valid,
    // [50:19] entry_vec_id, [82:51] entry_distance, [87:83] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = (K_ENTRIES > 1) ? $clog2(K_ENTRIES) : 1;
    localparam int CNT_W = $clog2(K_ENTRIES + 1);
    localparam logic [CNT_W-1:0] K_CNT = CNT_W'(K_ENTRIES);

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             first_reg, first_next;
    logic             out_valid_reg, out_valid_next;

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] id_reg;
    logic [DATA_W-1:0] dist_reg;
    logic [RIDX_W-1:0] ridx_reg;
    logic [IDX_W-1:0]  tag_reg;

    logic              res_acc_reg, res_acc_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic              res_valid_reg, res_valid_next;
    logic [DATA_W-1:0] res_id_reg, res_id_next;
    logic [DATA_W-1:0] res_dist_reg, res_dist_next;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic               take;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [ENTRY_W-1:0] mem_wdata;

    scan_ctrl_t        scan_ctrl;
    logic [IDX_W-1:0]  worst_idx;
    logic              scan_gt;

    assign s_tready  = (state_reg == ST_IDLE);
    assign take      = s_tvalid && s_tready;
    assign mem_wdata = {dist_reg, id_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    topk_mem #(
        .DEPTH  (K_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    topk_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk       (clk),
        .ctrl      (scan_ctrl),
        .cand_dist (mem_rdata[ENTRY_W-1:DATA_W]),
        .cand_idx  (tag_reg),
        .new_dist  (dist_reg),
        .worst_idx (worst_idx),
        .gt        (scan_gt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg  <= cmd_t'(s_tuser);
            id_reg   <= s_tdata[31:0];
            dist_reg <= s_tdata[63:32];
            ridx_reg <= s_tdata[71:64];
        end
        if (mem_re)
        begin
            tag_reg <= mem_raddr;
        end
        res_acc_reg   <= res_acc_next;
        res_slot_reg  <= res_slot_next;
        res_valid_reg <= res_valid_next;
        res_id_reg    <= res_id_next;
        res_dist_reg  <= res_dist_next;
        out_data_reg  <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !m_tready;
        res_acc_next   = res_acc_reg;
        res_slot_next  = res_slot_reg;
        res_valid_next = res_valid_reg;
        res_id_next    = res_id_reg;
        res_dist_next  = res_dist_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[IDX_W-1:0];
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg[IDX_W-1:0];
        scan_ctrl      = '{en: 1'b0, first: 1'b0, decide: 1'b0};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_acc_next   = 1'b0;
                res_slot_next  = '0;
                res_valid_next = 1'b0;
                res_id_next    = '0;
                res_dist_next  = '0;
                state_next     = ST_FINISH;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg < K_CNT)
                        begin
                            mem_we        = 1'b1;
                            res_acc_next  = 1'b1;
                            res_slot_next = SLOT_W'(count_reg);
                            count_next    = count_reg + 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            ptr_next   = CNT_W'(1);
                            first_next = 1'b1;
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_READ:
                    begin
                        if (HELD_W'(ridx_reg) < HELD_W'(count_reg))
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = ridx_reg[IDX_W-1:0];
                            state_next = ST_RDWAIT;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
            ST_SCAN:
            begin
                scan_ctrl  = '{en: 1'b1, first: first_reg, decide: 1'b0};
                first_next = 1'b0;
                if (ptr_reg < K_CNT)
                begin
                    mem_re   = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                scan_ctrl = '{en: 1'b0, first: 1'b0, decide: 1'b1};
                if (scan_gt)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = worst_idx;
                    res_acc_next  = 1'b1;
                    res_slot_next = SLOT_W'(worst_idx);
                end
                state_next = ST_FINISH;
            end
            ST_RDWAIT:
            begin
                res_valid_next = 1'b1;
                res_id_next    = mem_rdata[DATA_W-1:0];
                res_dist_next  = mem_rdata[ENTRY_W-1:DATA_W];
                state_next     = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0, res_dist_reg, res_id_reg, res_valid_reg,
                                      HELD_W'(count_reg), res_slot_reg, res_acc_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for topk_replace_worst: directed and random command streams
// under varied stream idling, checked against an in-bench model. Depends on topk_pkg.
module tb;
    import topk_pkg::*;

    localparam int K              = K_ENTRIES_DEF;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  slot;
        logic [8:0]  held;
        logic        entry_valid;
        logic [31:0] entry_id;
        logic [31:0] entry_dist;
    } topk_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]     s_tuser  = CMD_NOP;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [31:0]  tbl_id   [K];
    logic [31:0]  tbl_dist [K];
    int           tbl_fill = 0;
    topk_result_t expected_q[$];

    int   errors       = 0;
    int   cycles       = 0;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic rx_hold      = 1'b0;
    event rx_hold_ev;

    topk_replace_worst #(.K_ENTRIES(K)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(rx_hold_ev);
            @(posedge clk);
            rx_hold <= 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    function automatic topk_result_t predict_table(cmd_t op, logic [31:0] id,
                                                   logic [31:0] dist_val, logic [7:0] ridx);
        topk_result_t r;
        int           worst;
        r = '0;
        case (op)
            CMD_INSERT:
            begin
                if (tbl_fill < K)
                begin
                    tbl_id[tbl_fill]   = id;
                    tbl_dist[tbl_fill] = dist_val;
                    r.accepted         = 1'b1;
                    r.slot             = 8'(tbl_fill);
                    tbl_fill++;
                end
                else
                begin
                    worst = 0;
                    for (int i = 1; i < K; i++)
                        if (tbl_dist[i] > tbl_dist[worst])
                            worst = i;
                    if (dist_val < tbl_dist[worst])
                    begin
                        tbl_id[worst]   = id;
                        tbl_dist[worst] = dist_val;
                        r.accepted      = 1'b1;
                        r.slot          = 8'(worst);
                    end
                end
            end
            CMD_READ:
            begin
                if (ridx < tbl_fill && ridx < K)
                begin
                    r.entry_valid = 1'b1;
                    r.entry_id    = tbl_id[ridx];
                    r.entry_dist  = tbl_dist[ridx];
                end
            end
            CMD_CLEAR:
                tbl_fill = 0;
            default:
                ;
        endcase
        r.held = 9'(tbl_fill);
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        topk_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with nothing pending: m_tdata=%h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(m_tdata[0]));
                    check_field("slot", 32'(want.slot), 32'(m_tdata[8:1]));
                    check_field("held_count", 32'(want.held), 32'(m_tdata[17:9]));
                    check_field("entry_valid", 32'(want.entry_valid), 32'(m_tdata[18]));
                    check_field("entry_vec_id", want.entry_id, m_tdata[50:19]);
                    check_field("entry_distance", want.entry_dist, m_tdata[82:51]);
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_table(cmd_t'(s_tuser), s_tdata[31:0],
                                                   s_tdata[63:32], s_tdata[71:64]));
        end
    end

    task automatic send_item(cmd_t op, logic [31:0] id, logic [31:0] dist_val,
                             logic [7:0] ridx);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ridx, dist_val, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (expected_q.size() != 0);
        @(posedge clk);
    endtask

    task automatic set_idling(int tx, int rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    function automatic logic [31:0] random_distance();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 32'd0;
        else if (pick == 1)
            return 32'hFFFF_FFFF;
        else if (pick < 6)
            return $urandom_range(0, 31);
        return $urandom;
    endfunction

    function automatic logic [7:0] random_index();
        if ($urandom_range(0, 99) < 80)
            return 8'($urandom_range(0, K));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            send_item(CMD_CLEAR, $urandom, $urandom, random_index());
        else if (pick < 6)
            send_item(CMD_NOP, $urandom, $urandom, random_index());
        else if (pick < 30)
            send_item(CMD_READ, $urandom, $urandom, random_index());
        else
            send_item(CMD_INSERT, $urandom, random_distance(), random_index());
    endtask

    task automatic test_directed();
        send_item(CMD_READ, 32'd0, 32'd0, 8'd0);
        send_item(CMD_INSERT, 32'd0, 32'hFFFF_FFFF, 8'd0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'd0, 8'hFF);
        for (int i = 2; i < K; i++)
            send_item(CMD_INSERT, 32'h100 + i, (i == 5) ? 32'hFFFF_FFFF : 32'(i * 16), 8'd0);
        send_item(CMD_INSERT, 32'hAAAA_5555, 32'hFFFF_FFFF, 8'd0);
        send_item(CMD_INSERT, 32'h5555_AAAA, 32'd7, 8'd0);
        send_item(CMD_INSERT, 32'h1234_5678, 32'd8, 8'd0);
        send_item(CMD_READ, 32'd0, 32'd0, 8'd0);
        send_item(CMD_READ, 32'd0, 32'd0, 8'(K - 1));
        send_item(CMD_READ, 32'd0, 32'd0, 8'(K));
        send_item(CMD_READ, 32'd0, 32'd0, 8'hFF);
        send_item(CMD_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(CMD_CLEAR, 32'd0, 32'd0, 8'd0);
        send_item(CMD_READ, 32'd0, 32'd0, 8'd0);
    endtask

    task automatic test_random_queries(int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            send_item(CMD_CLEAR, $urandom, $urandom, random_index());
            len  = $urandom_range(20, 40);
            sent = sent + len + 1;
            repeat (len) send_random_item();
        end
    endtask

    task automatic test_output_backpressure();
        -> rx_hold_ev;
        repeat (12) send_random_item();
    endtask

    task automatic test_sender_pause();
        wait_results_drained();
        repeat (4) send_random_item();
        wait_results_drained();
        repeat (4) send_random_item();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0, 0);
        test_directed();
        test_random_queries(90);
        set_idling(66, 0);
        test_random_queries(90);
        set_idling(0, 66);
        test_random_queries(90);
        set_idling(38, 38);
        test_random_queries(90);
        set_idling(0, 0);
        test_output_backpressure();
        set_idling(38, 38);
        test_sender_pause();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_q.size());
            errors++;
        end
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
